// ===== src/afu_pkg.sv =====
// Shared constants, types and breakpoint functions for the activation unit.
`default_nettype none

package afu_pkg;

	localparam int unsigned SEGMENTS_DEFAULT = 64;
	localparam int unsigned IN_WIDTH_DEFAULT = 16;
	localparam int unsigned OUT_WIDTH        = 16;
	localparam int unsigned MAG_WIDTH        = 15;
	localparam int unsigned ONE_Q14          = 16384;

	localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
	localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

	localparam logic [1:0] FN_SIGMOID = 2'd0;
	localparam logic [1:0] FN_TANH    = 2'd1;
	localparam logic [1:0] FN_DSIG    = 2'd2;
	localparam logic [1:0] FN_DTANH   = 2'd3;

	typedef struct packed {
		logic       neg;
		logic       sat;
		logic [1:0] fsel;
		logic       last;
	} ctl_t;

	// Restoring long division, used only while building constant tables.
	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
		logic [63:0] q;
		logic [63:0] rem;
		q   = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem  = rem - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-t) in Q0.30 at breakpoint k: Taylor series at t/128, squared seven times.
	function automatic logic [63:0] exp_neg_q30(int unsigned k, int unsigned segs);
		logic [63:0]        u;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        e;
		u    = udiv64(64'(k) << 30, 64'(segs) << 4);
		term = ONE_Q30;
		sum  = $signed(ONE_Q30);
		for (int n = 1; n <= 10; n++) begin
			term = udiv64((term * u) >> 30, 64'(n));
			if (n[0]) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		e = $unsigned(sum);
		for (int i = 0; i < 7; i++) begin
			e = (e * e + HALF_Q30) >> 30;
		end
		return e;
	endfunction

	// Q1.14 breakpoint value of one function over |x|, clamped to [0, 1.0].
	function automatic logic [MAG_WIDTH-1:0] bp_value(logic [1:0] fsel, int unsigned k,
			int unsigned segs);
		logic [63:0] e;
		logic [63:0] d;
		logic [63:0] e2;
		logic [63:0] d2;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] v;
		e  = exp_neg_q30(k, segs);
		d  = ONE_Q30 + e;
		e2 = (e * e + HALF_Q30) >> 30;
		d2 = ONE_Q30 + e2;
		a  = udiv64((e << 30) + (d >> 1), d);
		b  = udiv64((e2 << 32) + (d2 >> 1), d2);
		unique case (fsel)
			FN_SIGMOID: v = udiv64((64'd1 << 44) + (d >> 1), d);
			FN_TANH:    v = udiv64(((ONE_Q30 - e2) << 14) + (d2 >> 1), d2);
			FN_DSIG:    v = udiv64((a << 14) + (d >> 1), d);
			FN_DTANH:   v = udiv64((b << 14) + (d2 >> 1), d2);
			default:    v = '0;
		endcase
		if (v > 64'(ONE_Q14)) begin
			v = 64'(ONE_Q14);
		end
		return MAG_WIDTH'(v);
	endfunction

endpackage

`default_nettype wire

// ===== src/activation_function_unit.sv =====
// Top level of the piecewise-linear sigmoid / tanh activation unit.
//
//   port group      dir   handshake             payload
//   in_*            in    in_valid / in_ready   x_value, last_in
//   out_*           out   out_valid / out_ready y_value, last_out
//   cfg_*           in    cfg_write_en          cfg_write_data (function select)
//
// One item per cycle sustained while out_ready holds high; four register stages (decode,
// table read, interpolation multiply, round and sign restore), the first loading at the
// transfer edge and each later stage registering the one before it.
// Every stage has its own valid bit and moves when the stage after it has room,
// so bubbles close up and a stalled output holds without loss.
// Reset empties the pipeline and selects the sigmoid.
`default_nettype none

module activation_function_unit #(
	parameter int unsigned TABLE_SEGMENTS = afu_pkg::SEGMENTS_DEFAULT,
	parameter int unsigned INPUT_WIDTH    = afu_pkg::IN_WIDTH_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write_en,
	input  wire logic [1:0]                        cfg_write_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [INPUT_WIDTH-1:0]     x_value,
	input  wire logic                              last_in,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [afu_pkg::OUT_WIDTH-1:0]   y_value,
	output logic                                   last_out
);

	localparam int unsigned SEG_WIDTH = $clog2(TABLE_SEGMENTS);
	localparam int unsigned POS_WIDTH = INPUT_WIDTH + SEG_WIDTH;

	logic [1:0]                    fsel_q;

	logic                          v_s1;
	logic                          v_s2;
	logic                          en_s1;
	logic                          en_s2;
	logic                          lerp_ready;

	logic [SEG_WIDTH-1:0]          seg_s1;
	logic [INPUT_WIDTH-2:0]        frac_s1;
	afu_pkg::ctl_t                 ctl_s1;

	logic [afu_pkg::MAG_WIDTH-1:0] lo_s2;
	logic [afu_pkg::MAG_WIDTH-1:0] hi_s2;
	logic [INPUT_WIDTH-2:0]        frac_s2;
	afu_pkg::ctl_t                 ctl_s2;

	logic [INPUT_WIDTH-1:0]        x_u;
	logic [INPUT_WIDTH-1:0]        mag;
	logic [POS_WIDTH-1:0]          pos;
	logic [afu_pkg::MAG_WIDTH-1:0] y_lo;
	logic [afu_pkg::MAG_WIDTH-1:0] y_hi;
	afu_pkg::ctl_t                 ctl_d;

	assign en_s2    = !v_s2 || lerp_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// |x| stays in INPUT_WIDTH bits; only the most negative input reaches 8.0
	assign x_u = x_value;
	assign mag = x_u[INPUT_WIDTH-1] ? (~x_u + INPUT_WIDTH'(1)) : x_u;
	assign pos = POS_WIDTH'(mag) * POS_WIDTH'(TABLE_SEGMENTS);

	always_comb begin
		ctl_d.neg  = x_u[INPUT_WIDTH-1];
		ctl_d.sat  = mag[INPUT_WIDTH-1];
		ctl_d.fsel = fsel_q;
		ctl_d.last = last_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsel_q <= afu_pkg::FN_SIGMOID;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			if (cfg_write_en) fsel_q <= cfg_write_data;
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			seg_s1  <= pos[INPUT_WIDTH-1 +: SEG_WIDTH];
			frac_s1 <= pos[INPUT_WIDTH-2:0];
			ctl_s1  <= ctl_d;
		end
		if (en_s2) begin
			lo_s2   <= y_lo;
			hi_s2   <= y_hi;
			frac_s2 <= frac_s1;
			ctl_s2  <= ctl_s1;
		end
	end

	afu_rom #(
		.TABLE_SEGMENTS (TABLE_SEGMENTS),
		.SEG_WIDTH      (SEG_WIDTH)
	) u_rom (
		.fsel (ctl_s1.fsel),
		.seg  (seg_s1),
		.y_lo (y_lo),
		.y_hi (y_hi)
	);

	afu_lerp #(
		.INPUT_WIDTH (INPUT_WIDTH)
	) u_lerp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (lerp_ready),
		.y_lo      (lo_s2),
		.y_hi      (hi_s2),
		.frac      (frac_s2),
		.ctl       (ctl_s2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.y_value   (y_value),
		.last_out  (last_out)
	);

endmodule

`default_nettype wire

// ===== src/afu_rom.sv =====
// Breakpoint tables for all four functions: lower and upper end of each segment.
`default_nettype none

module afu_rom #(
	parameter int unsigned TABLE_SEGMENTS = afu_pkg::SEGMENTS_DEFAULT,
	parameter int unsigned SEG_WIDTH      = $clog2(TABLE_SEGMENTS)
) (
	input  wire logic [1:0]                     fsel,
	input  wire logic [SEG_WIDTH-1:0]           seg,
	output logic      [afu_pkg::MAG_WIDTH-1:0]  y_lo,
	output logic      [afu_pkg::MAG_WIDTH-1:0]  y_hi
);

	logic [afu_pkg::MAG_WIDTH-1:0] tab_lo [4][TABLE_SEGMENTS];
	logic [afu_pkg::MAG_WIDTH-1:0] tab_hi [4][TABLE_SEGMENTS];

	for (genvar f = 0; f < 4; f++) begin : g_fn
		for (genvar k = 0; k < TABLE_SEGMENTS; k++) begin : g_bp
			localparam logic [afu_pkg::MAG_WIDTH-1:0] LO =
				afu_pkg::bp_value(2'(f), k, TABLE_SEGMENTS);
			localparam logic [afu_pkg::MAG_WIDTH-1:0] HI =
				afu_pkg::bp_value(2'(f), k + 1, TABLE_SEGMENTS);
			assign tab_lo[f][k] = LO;
			assign tab_hi[f][k] = HI;
		end
	end

	assign y_lo = tab_lo[fsel][seg];
	assign y_hi = tab_hi[fsel][seg];

endmodule

`default_nettype wire

// ===== src/afu_lerp.sv =====
// Interpolation multiply, rounding and sign restore; last two pipeline stages.
`default_nettype none

module afu_lerp #(
	parameter int unsigned INPUT_WIDTH = afu_pkg::IN_WIDTH_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [afu_pkg::MAG_WIDTH-1:0]     y_lo,
	input  wire logic [afu_pkg::MAG_WIDTH-1:0]     y_hi,
	input  wire logic [INPUT_WIDTH-2:0]            frac,
	input  wire afu_pkg::ctl_t                     ctl,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [afu_pkg::OUT_WIDTH-1:0]   y_value,
	output logic                                   last_out
);

	localparam int unsigned AW = INPUT_WIDTH + 16;

	logic                                  v_s3;
	logic                                  en_s3;
	logic                                  en_s4;
	logic signed [AW-1:0]                  prod_s3;
	logic [afu_pkg::MAG_WIDTH-1:0]         lo_s3;
	afu_pkg::ctl_t                         ctl_s3;

	logic signed [15:0]                    diff;
	logic signed [INPUT_WIDTH-1:0]         frac_sg;
	logic signed [AW-1:0]                  prod_d;
	logic signed [AW-1:0]                  base;
	logic signed [AW-1:0]                  acc;
	logic [afu_pkg::MAG_WIDTH-1:0]         mval;
	logic signed [afu_pkg::OUT_WIDTH-1:0]  y_d;

	assign en_s4    = !out_valid || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	assign diff    = $signed({1'b0, y_hi}) - $signed({1'b0, y_lo});
	assign frac_sg = $signed({1'b0, frac});
	assign prod_d  = diff * frac_sg;

	// y0*P + (y1-y0)*f + P/2, then drop the fraction bits
	assign base = $signed({2'b00, lo_s3, {(INPUT_WIDTH-1){1'b0}}});
	assign acc  = base + prod_s3 + (AW'(1) <<< (INPUT_WIDTH - 2));
	assign mval = acc[INPUT_WIDTH-1 +: afu_pkg::MAG_WIDTH];

	always_comb begin
		logic [afu_pkg::MAG_WIDTH-1:0] m;
		m = mval;
		if (ctl_s3.sat) begin
			m = (ctl_s3.fsel == afu_pkg::FN_DSIG || ctl_s3.fsel == afu_pkg::FN_DTANH)
				? '0 : afu_pkg::MAG_WIDTH'(afu_pkg::ONE_Q14);
		end
		if (ctl_s3.neg && ctl_s3.fsel == afu_pkg::FN_SIGMOID) begin
			y_d = $signed(afu_pkg::OUT_WIDTH'(afu_pkg::ONE_Q14)) - $signed({1'b0, m});
		end else if (ctl_s3.neg && ctl_s3.fsel == afu_pkg::FN_TANH) begin
			y_d = -$signed({1'b0, m});
		end else begin
			y_d = $signed({1'b0, m});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			prod_s3 <= prod_d;
			lo_s3   <= y_lo;
			ctl_s3  <= ctl;
		end
		if (en_s4) begin
			y_value  <= y_d;
			last_out <= ctl_s3.last;
		end
	end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the activation unit: directed table, random phases, stalls.

module tb;

	localparam int     SEGMENTS    = 64;
	localparam int     IN_BITS     = 16;
	localparam longint HALF_SPAN   = longint'(1) << (IN_BITS - 1);
	localparam longint Q30         = longint'(1) << 30;
	localparam longint Q14_ONE     = 16384;
	localparam int     PIPE_DEPTH  = 4;
	localparam int     PHASES      = 8;
	localparam int     PHASE_ITEMS = 166;
	localparam int     HOLDOFF     = 64;

	localparam logic [1:0] PHASE_FN [6] = '{afu_pkg::FN_SIGMOID, afu_pkg::FN_DTANH,
		afu_pkg::FN_TANH, afu_pkg::FN_DSIG, afu_pkg::FN_SIGMOID, afu_pkg::FN_DTANH};

	typedef struct {
		logic signed [afu_pkg::OUT_WIDTH-1:0] y;
		logic                                 last;
	} activation_t;

	typedef struct {
		logic [1:0]                           fsel;
		logic signed [IN_BITS-1:0]            x;
		logic                                 last;
		bit                                   typed;
		logic signed [afu_pkg::OUT_WIDTH-1:0] y;
	} sample_row_t;

	logic                                 clk            = 1'b0;
	logic                                 arst_n         = 1'b0;
	logic                                 cfg_write_en   = 1'b0;
	logic [1:0]                           cfg_write_data = afu_pkg::FN_SIGMOID;
	logic                                 in_valid       = 1'b0;
	logic                                 in_ready;
	logic signed [IN_BITS-1:0]            x_value        = '0;
	logic                                 last_in        = 1'b0;
	logic                                 out_valid;
	logic                                 out_ready      = 1'b0;
	logic signed [afu_pkg::OUT_WIDTH-1:0] y_value;
	logic                                 last_out;

	longint      breakpoint_q14 [4][SEGMENTS+1];
	activation_t expected_activations [$];
	logic [1:0]  active_fsel   = afu_pkg::FN_SIGMOID;
	bit          stall_request = 1'b0;
	int          error_count   = 0;

	// Typed values: zero and the saturated most negative input of every function.
	sample_row_t directed_rows [24] = '{
		'{afu_pkg::FN_SIGMOID,      16'sd0, 1'b0, 1'b1,   16'sd8192},
		'{afu_pkg::FN_SIGMOID, -16'sd32768, 1'b1, 1'b1,      16'sd0},
		'{afu_pkg::FN_SIGMOID,  16'sd32767, 1'b0, 1'b0,      16'sd0},
		'{afu_pkg::FN_SIGMOID, -16'sd32767, 1'b0, 1'b0,      16'sd0},
		'{afu_pkg::FN_SIGMOID,    16'sd512, 1'b1, 1'b0,      16'sd0},
		'{afu_pkg::FN_SIGMOID,     -16'sd1, 1'b0, 1'b0,      16'sd0},
		'{afu_pkg::FN_TANH,         16'sd0, 1'b1, 1'b1,      16'sd0},
		'{afu_pkg::FN_TANH,    -16'sd32768, 1'b0, 1'b1, -16'sd16384},
		'{afu_pkg::FN_TANH,     16'sd32767, 1'b0, 1'b0,      16'sd0},
		'{afu_pkg::FN_TANH,    -16'sd32767, 1'b1, 1'b0,      16'sd0},
		'{afu_pkg::FN_TANH,       16'sd512, 1'b0, 1'b0,      16'sd0},
		'{afu_pkg::FN_TANH,        -16'sd1, 1'b0, 1'b0,      16'sd0},
		'{afu_pkg::FN_DSIG,         16'sd0, 1'b0, 1'b1,   16'sd4096},
		'{afu_pkg::FN_DSIG,    -16'sd32768, 1'b1, 1'b1,      16'sd0},
		'{afu_pkg::FN_DSIG,     16'sd32767, 1'b0, 1'b0,      16'sd0},
		'{afu_pkg::FN_DSIG,    -16'sd32767, 1'b0, 1'b0,      16'sd0},
		'{afu_pkg::FN_DSIG,       16'sd512, 1'b1, 1'b0,      16'sd0},
		'{afu_pkg::FN_DSIG,        -16'sd1, 1'b0, 1'b0,      16'sd0},
		'{afu_pkg::FN_DTANH,        16'sd0, 1'b0, 1'b1,  16'sd16384},
		'{afu_pkg::FN_DTANH,   -16'sd32768, 1'b0, 1'b1,      16'sd0},
		'{afu_pkg::FN_DTANH,    16'sd32767, 1'b1, 1'b0,      16'sd0},
		'{afu_pkg::FN_DTANH,   -16'sd32767, 1'b0, 1'b0,      16'sd0},
		'{afu_pkg::FN_DTANH,      16'sd512, 1'b0, 1'b0,      16'sd0},
		'{afu_pkg::FN_DTANH,       -16'sd1, 1'b1, 1'b0,      16'sd0}
	};

	activation_function_unit #(
		.TABLE_SEGMENTS(SEGMENTS),
		.INPUT_WIDTH   (IN_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.x_value       (x_value),
		.last_in       (last_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.y_value       (y_value),
		.last_out      (last_out)
	);

	always #2 clk = ~clk;

	function automatic longint clamp_q14(longint v);
		if (v < 0) begin
			return 0;
		end
		return (v > Q14_ONE) ? Q14_ONE : v;
	endfunction

	// exp(-t) in Q0.30: series at t/128, then squared seven times.
	function automatic longint exp_neg_at(int k);
		longint u;
		longint term;
		longint sum;
		u    = (longint'(k) << 30) / (16 * SEGMENTS);
		term = Q30;
		sum  = Q30;
		for (int n = 1; n <= 10; n++) begin
			term = ((term * u) >> 30) / n;
			if (n % 2) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		for (int i = 0; i < 7; i++) begin
			sum = (sum * sum + Q30 / 2) >> 30;
		end
		return sum;
	endfunction

	function automatic void build_breakpoints();
		longint e;
		longint d;
		longint e2;
		longint d2;
		longint a;
		longint b;
		for (int k = 0; k <= SEGMENTS; k++) begin
			e  = exp_neg_at(k);
			d  = Q30 + e;
			e2 = (e * e + Q30 / 2) >> 30;
			d2 = Q30 + e2;
			a  = (e * Q30 + d / 2) / d;
			b  = (4 * e2 * Q30 + d2 / 2) / d2;
			breakpoint_q14[afu_pkg::FN_SIGMOID][k] =
				clamp_q14(((longint'(1) << 44) + d / 2) / d);
			breakpoint_q14[afu_pkg::FN_TANH][k] =
				clamp_q14(((Q30 - e2) * Q14_ONE + d2 / 2) / d2);
			breakpoint_q14[afu_pkg::FN_DSIG][k] =
				clamp_q14((a * Q14_ONE + d / 2) / d);
			breakpoint_q14[afu_pkg::FN_DTANH][k] =
				clamp_q14((b * Q14_ONE + d2 / 2) / d2);
		end
	endfunction

	function automatic logic signed [afu_pkg::OUT_WIDTH-1:0] predict_activation(
			logic [1:0] fsel, logic signed [IN_BITS-1:0] x);
		bit     neg;
		longint mag;
		longint pos;
		longint seg;
		longint frac;
		longint mval;
		longint y;
		neg  = x[IN_BITS-1];
		mag  = neg ? -longint'(x) : longint'(x);
		pos  = mag * SEGMENTS;
		seg  = pos >> (IN_BITS - 1);
		frac = pos & (HALF_SPAN - 1);
		// Only the most negative input runs off the table; use the asymptote.
		if (seg >= SEGMENTS) begin
			mval = (fsel == afu_pkg::FN_DSIG || fsel == afu_pkg::FN_DTANH) ? 0 : Q14_ONE;
		end else begin
			mval = (breakpoint_q14[fsel][seg] * (HALF_SPAN - frac)
				+ breakpoint_q14[fsel][seg+1] * frac + HALF_SPAN / 2) >> (IN_BITS - 1);
		end
		if (neg && fsel == afu_pkg::FN_SIGMOID) begin
			y = Q14_ONE - mval;
		end else if (neg && fsel == afu_pkg::FN_TANH) begin
			y = -mval;
		end else begin
			y = mval;
		end
		return afu_pkg::OUT_WIDTH'(y);
	endfunction

	function automatic logic signed [IN_BITS-1:0] next_sample();
		int unsigned pick;
		logic signed [IN_BITS-1:0] v;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			v = IN_BITS'($urandom);
		end else if (pick < 7) begin
			v = IN_BITS'(int'($urandom_range(0, 511)) - 256);
		end else if (pick < 8) begin
			v = $urandom_range(0, 1) ? IN_BITS'(32767 - int'($urandom_range(0, 15)))
				: IN_BITS'(-32768 + int'($urandom_range(0, 15)));
		end else begin
			// Land on or right next to a breakpoint.
			v = IN_BITS'(int'($urandom_range(0, 63)) * 512 + int'($urandom_range(0, 2)) - 1);
			if ($urandom_range(0, 1)) begin
				v = -v;
			end
		end
		return v;
	endfunction

	task automatic present_sample(input logic signed [IN_BITS-1:0] x, input logic lst,
			input bit typed, input logic signed [afu_pkg::OUT_WIDTH-1:0] typed_y);
		activation_t want;
		in_valid <= 1'b1;
		x_value  <= x;
		last_in  <= lst;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		want.y    = typed ? typed_y : predict_activation(active_fsel, x);
		want.last = lst;
		expected_activations = {expected_activations, want};
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Drain the pipeline, then switch the function while idle.
	task automatic settle_and_select(input logic [1:0] fsel);
		in_valid <= 1'b0;
		while (expected_activations.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_DEPTH) @(posedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= fsel;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		active_fsel = fsel;
	endtask

	initial begin : stimulus
		int burst_left;
		bit steady;
		build_breakpoints();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			if (i == 0 || directed_rows[i].fsel != active_fsel) begin
				settle_and_select(directed_rows[i].fsel);
			end
			pause_sender($urandom_range(0, 2));
			present_sample(directed_rows[i].x, directed_rows[i].last, directed_rows[i].typed,
				directed_rows[i].y);
		end
		for (int p = 0; p < PHASES; p++) begin
			settle_and_select(p < 6 ? PHASE_FN[p] : 2'($urandom_range(0, 3)));
			steady     = (p == 1 || p == 2);
			burst_left = 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Hold the output off while the sender keeps pushing.
				if (p == 2 && n == 20) begin
					stall_request = 1'b1;
				end
				if (!steady && burst_left == 0) begin
					pause_sender($urandom_range(0, 6));
					burst_left = $urandom_range(1, 24);
				end
				present_sample(next_sample(), $urandom_range(0, 7) == 0, 1'b0, '0);
				if (burst_left > 0) begin
					burst_left--;
				end
			end
		end
		in_valid <= 1'b0;
		while (expected_activations.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_DEPTH * 4) @(posedge clk);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin : output_pacing
		int rx_cycle;
		int hold_left;
		rx_cycle  = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				hold_left     = HOLDOFF;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case ((rx_cycle / 256) % 4)
					0:       out_ready <= 1'b1;
					1:       out_ready <= $urandom_range(0, 1);
					2:       out_ready <= ($urandom_range(0, 7) != 0);
					default: out_ready <= (rx_cycle % 3 == 0);
				endcase
			end
			rx_cycle++;
		end
	end

	always @(posedge clk) begin
		activation_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_activations.size() == 0) begin
				$error("unexpected transfer: y_value %0d, last_out %0b", y_value, last_out);
				error_count++;
			end else begin
				want = expected_activations.pop_front();
				if (y_value !== want.y) begin
					$error("y_value: expected %0d, got %0d", want.y, y_value);
					error_count++;
				end
				if (last_out !== want.last) begin
					$error("last_out: expected %0b, got %0b", want.last, last_out);
					error_count++;
				end
			end
		end
	end

	initial begin : watchdog
		#2ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
